// ===== rtl/core/thri_pkg.sv =====
// ----------------------------------------------------------------------------
// thri_pkg
// Shared types and codes for the timed history rewind interpolator.
// ----------------------------------------------------------------------------
package thri_pkg;

   localparam logic [1:0] OP_RECORD   = 2'd0;
   localparam logic [1:0] OP_REWIND   = 2'd1;
   localparam logic [1:0] OP_UNDO     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_RECORDED = 2'd1;
   localparam logic [1:0] ACT_REWOUND  = 2'd2;
   localparam logic [1:0] ACT_RESTORED = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [30:0] frame_time;
      logic [30:0] previous_frame_time;
      logic [15:0] elapsed_ms;
      logic        is_bot;
      logic [30:0] query_time;
      logic [59:0] position;
      logic [47:0] orientation;
      logic [59:0] box_low;
      logic [59:0] box_high;
      logic [15:0] motion_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [59:0] out_position;
      logic [47:0] out_orientation;
      logic [59:0] out_box_low;
      logic [59:0] out_box_high;
      logic [15:0] out_motion_flags;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_RD,
      ST_REC_CHK,
      ST_REC_WR,
      ST_RW_RD,
      ST_RW_CHK,
      ST_RW_OLD_RD,
      ST_RW_OLD,
      ST_RW_B,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_UNDO,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_REC_READ,
      CMD_REC_FIX,
      CMD_REC_WRITE,
      CMD_RW_READ,
      CMD_RW_STEP,
      CMD_RW_SAVE_A,
      CMD_RW_READ_TO,
      CMD_TAKE_OLDEST,
      CMD_LOAD_B,
      CMD_DIV_STEP,
      CMD_LERP_MUL,
      CMD_LERP_ADD,
      CMD_RESTORE,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic first;
      logic wrap_next;
      logic div_last;
      logic lane_last;
      logic out_busy;
   } status_type;

endpackage

// ===== rtl/core/thri_req_if.sv =====
// ----------------------------------------------------------------------------
// thri_req_if
// Request channel: valid/ready handshake with the object state and query.
// ----------------------------------------------------------------------------
interface thri_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [30:0] frame_time;
   logic [30:0] previous_frame_time;
   logic [15:0] elapsed_ms;
   logic        is_bot;
   logic [30:0] query_time;
   logic [59:0] position;
   logic [47:0] orientation;
   logic [59:0] box_low;
   logic [59:0] box_high;
   logic [15:0] motion_flags;

   modport source (
      output valid, opcode, frame_time, previous_frame_time, elapsed_ms, is_bot,
             query_time, position, orientation, box_low, box_high, motion_flags,
      input  ready
   );

   modport sink (
      input  valid, opcode, frame_time, previous_frame_time, elapsed_ms, is_bot,
             query_time, position, orientation, box_low, box_high, motion_flags,
      output ready
   );
endinterface

// ===== rtl/core/thri_rsp_if.sv =====
// ----------------------------------------------------------------------------
// thri_rsp_if
// Response channel: valid/ready handshake with the resulting object state.
// ----------------------------------------------------------------------------
interface thri_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [59:0] out_position;
   logic [47:0] out_orientation;
   logic [59:0] out_box_low;
   logic [59:0] out_box_high;
   logic [15:0] out_motion_flags;

   modport source (
      output valid, action, out_position, out_orientation, out_box_low,
             out_box_high, out_motion_flags,
      input  ready
   );

   modport sink (
      input  valid, action, out_position, out_orientation, out_box_low,
             out_box_high, out_motion_flags,
      output ready
   );
endinterface

// ===== rtl/core/thri_ctrl.sv =====
// ----------------------------------------------------------------------------
// thri_ctrl
// Sequencer: steps the datapath through record, rewind search, divide,
// lane interpolation, undo and result hand-off.
// ----------------------------------------------------------------------------
module thri_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   input  thri_pkg::status_type   status,
   output thri_pkg::cmd_type      cmd,
   output logic                   req_ready
);
   import thri_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  OP_RECORD: state_in = ST_REC_RD;
                  OP_REWIND: state_in = ST_RW_RD;
                  OP_UNDO:   state_in = ST_UNDO;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_REC_RD:    state_in = ST_REC_CHK;
         ST_REC_CHK:   state_in = ST_REC_WR;
         ST_REC_WR:    state_in = ST_FINISH;
         ST_RW_RD:     state_in = ST_RW_CHK;
         ST_RW_CHK: begin
            if (status.hit) begin
               state_in = status.first ? ST_FINISH : ST_RW_B;
            end else begin
               state_in = status.wrap_next ? ST_RW_OLD_RD : ST_RW_RD;
            end
         end
         ST_RW_OLD_RD: state_in = ST_RW_OLD;
         ST_RW_OLD:    state_in = ST_FINISH;
         ST_RW_B:      state_in = ST_DIV;
         ST_DIV:       state_in = status.div_last ? ST_MUL : ST_DIV;
         ST_MUL:       state_in = ST_ADD;
         ST_ADD:       state_in = status.lane_last ? ST_FINISH : ST_MUL;
         ST_UNDO:      state_in = ST_FINISH;
         ST_FINISH:    state_in = status.out_busy ? ST_FINISH : ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd       = req_valid ? CMD_ACCEPT : CMD_NONE;
         end
         ST_REC_RD:    cmd = CMD_REC_READ;
         ST_REC_CHK:   cmd = CMD_REC_FIX;
         ST_REC_WR:    cmd = CMD_REC_WRITE;
         ST_RW_RD:     cmd = CMD_RW_READ;
         ST_RW_CHK: begin
            if (status.hit) begin
               cmd = status.first ? CMD_NONE : CMD_RW_SAVE_A;
            end else begin
               cmd = CMD_RW_STEP;
            end
         end
         ST_RW_OLD_RD: cmd = CMD_RW_READ_TO;
         ST_RW_OLD:    cmd = CMD_TAKE_OLDEST;
         ST_RW_B:      cmd = CMD_LOAD_B;
         ST_DIV:       cmd = CMD_DIV_STEP;
         ST_MUL:       cmd = CMD_LERP_MUL;
         ST_ADD:       cmd = CMD_LERP_ADD;
         ST_UNDO:      cmd = CMD_RESTORE;
         ST_FINISH:    cmd = status.out_busy ? CMD_NONE : CMD_EMIT;
         default:      cmd = CMD_NONE;
      endcase
   end

endmodule

// ===== rtl/core/thri_dp.sv =====
// ----------------------------------------------------------------------------
// thri_dp
// Datapath: snapshot history memory, head pointer, undo slot, restoring
// divider for the fraction, one shared lane multiplier and result register.
// ----------------------------------------------------------------------------
module thri_dp #(
   parameter int HISTORY_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  thri_pkg::cmd_type    cmd,
   input  thri_pkg::req_type    req_data,
   output thri_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output thri_pkg::rsp_type    rsp_data
);
   import thri_pkg::*;

   localparam int IW = $clog2(HISTORY_DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(HISTORY_DEPTH - 1);

   typedef struct packed {
      logic [30:0] frame;
      logic [30:0] sample;
      logic [59:0] position;
      logic [47:0] orientation;
      logic [59:0] box_low;
      logic [59:0] box_high;
      logic [15:0] flags;
   } entry_type;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [IW-1:0] prev_slot(input logic [IW-1:0] s);
      return (s == '0) ? LAST_SLOT : s - 1'b1;
   endfunction

   function automatic logic signed [20:0] lane20(input logic [59:0] v,
                                                 input logic [1:0] sub);
      logic [19:0] x;
      unique case (sub)
         2'd0:    x = v[19:0];
         2'd1:    x = v[39:20];
         default: x = v[59:40];
      endcase
      return $signed({x[19], x});
   endfunction

   function automatic logic signed [20:0] lane16(input logic [47:0] v,
                                                 input logic [1:0] sub);
      logic [15:0] x;
      unique case (sub)
         2'd0:    x = v[15:0];
         2'd1:    x = v[31:16];
         default: x = v[47:32];
      endcase
      return $signed({{5{x[15]}}, x});
   endfunction

   function automatic logic [30:0] sample_time(input req_type r);
      logic [31:0] t;
      logic [30:0] res;
      t = {1'b0, r.previous_frame_time} + 32'(r.elapsed_ms);
      if (r.is_bot) begin
         res = r.frame_time;
      end else if (t > {1'b0, r.frame_time}) begin
         res = r.frame_time;
      end else if (t <= {1'b0, r.previous_frame_time}) begin
         res = (&r.previous_frame_time) ? r.previous_frame_time
                                        : r.previous_frame_time + 31'd1;
      end else begin
         res = t[30:0];
      end
      return res;
   endfunction

   // history memory
   entry_type             mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;
   entry_type             rd_ff;
   logic                  mem_we;
   logic [IW-1:0]         mem_wa;
   entry_type             mem_wd;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;

   // control registers
   logic [IW-1:0] head_ff, head_in;
   logic          out_valid_ff, out_valid_in;
   logic [30:0]   undo_stamp_ff, undo_stamp_in;
   rsp_type       undo_ff, undo_in;
   logic [3:0]    div_cnt_ff, div_cnt_in;
   logic [1:0]    grp_ff, grp_in;
   logic [1:0]    sub_ff, sub_in;

   // payload registers
   req_type              req_ff, req_in;
   logic [30:0]          q_ff, q_in;
   logic [IW-1:0]        from_ff, from_in;
   logic [IW-1:0]        to_ff, to_in;
   rsp_type              res_ff, res_in;
   rsp_type              out_ff, out_in;
   entry_type            a_ff, a_in;
   entry_type            b_ff, b_in;
   logic [31:0]          rem_ff, rem_in;
   logic [30:0]          divisor_ff, divisor_in;
   logic [15:0]          quo_ff, quo_in;
   logic                 div_ok_ff, div_ok_in;
   logic signed [37:0]   prod_ff, prod_in;

   logic signed [20:0]   va;
   logic signed [20:0]   vb;
   logic signed [20:0]   diff;
   logic signed [16:0]   frac_s;
   logic signed [37:0]   rounded;
   logic signed [37:0]   scaled;
   logic [19:0]          lane_new;
   logic [31:0]          rem_shift;
   logic [IW-1:0]        from_prev;

   assign from_prev = prev_slot(from_ff);

   always_comb begin
      unique case (grp_ff)
         2'd0: begin
            va = lane20(a_ff.position, sub_ff);
            vb = lane20(b_ff.position, sub_ff);
         end
         2'd1: begin
            va = lane16(a_ff.orientation, sub_ff);
            vb = lane16(b_ff.orientation, sub_ff);
         end
         2'd2: begin
            va = lane20(a_ff.box_low, sub_ff);
            vb = lane20(b_ff.box_low, sub_ff);
         end
         default: begin
            va = lane20(a_ff.box_high, sub_ff);
            vb = lane20(b_ff.box_high, sub_ff);
         end
      endcase
   end

   assign diff      = vb - va;
   assign frac_s    = $signed({1'b0, (div_ok_ff ? quo_ff : 16'd0)});
   assign rounded   = prod_ff + 38'sd32768;
   assign scaled    = rounded >>> 16;
   assign lane_new  = va[19:0] + scaled[19:0];
   assign rem_shift = {rem_ff[30:0], 1'b0};

   always_comb begin
      head_in       = head_ff;
      out_valid_in  = out_valid_ff;
      undo_stamp_in = undo_stamp_ff;
      undo_in       = undo_ff;
      div_cnt_in    = div_cnt_ff;
      grp_in        = grp_ff;
      sub_in        = sub_ff;
      req_in        = req_ff;
      q_in          = q_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      quo_in        = quo_ff;
      div_ok_in     = div_ok_ff;
      prod_in       = prod_ff;
      mem_we        = 1'b0;
      mem_wa        = head_ff;
      mem_wd        = rd_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (cmd)
         CMD_ACCEPT: begin
            req_in  = req_data;
            q_in    = (req_data.query_time > req_data.frame_time) ?
                      req_data.frame_time : req_data.query_time;
            from_in = head_ff;
            to_in   = head_ff;
            res_in.action           = ACT_NONE;
            res_in.out_position     = req_data.position;
            res_in.out_orientation  = req_data.orientation;
            res_in.out_box_low      = req_data.box_low;
            res_in.out_box_high     = req_data.box_high;
            res_in.out_motion_flags = req_data.motion_flags;
            grp_in     = 2'd0;
            sub_in     = 2'd0;
            div_cnt_in = 4'd0;
         end
         CMD_REC_READ: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         CMD_REC_FIX: begin
            if (rd_ff.frame < req_ff.frame_time) begin
               mem_we        = 1'b1;
               mem_wa        = head_ff;
               mem_wd        = rd_ff;
               mem_wd.sample = req_ff.previous_frame_time;
               head_in       = next_slot(head_ff);
            end
         end
         CMD_REC_WRITE: begin
            mem_we             = 1'b1;
            mem_wa             = head_ff;
            mem_wd.frame       = req_ff.frame_time;
            mem_wd.sample      = sample_time(req_ff);
            mem_wd.position    = req_ff.position;
            mem_wd.orientation = req_ff.orientation;
            mem_wd.box_low     = req_ff.box_low;
            mem_wd.box_high    = req_ff.box_high;
            mem_wd.flags       = req_ff.motion_flags;
            res_in.action      = ACT_RECORDED;
         end
         CMD_RW_READ: begin
            rd_en   = 1'b1;
            rd_addr = from_ff;
         end
         CMD_RW_STEP: begin
            to_in   = from_ff;
            from_in = from_prev;
         end
         CMD_RW_SAVE_A: begin
            a_in    = rd_ff;
            rd_en   = 1'b1;
            rd_addr = to_ff;
         end
         CMD_RW_READ_TO: begin
            rd_en   = 1'b1;
            rd_addr = to_ff;
         end
         CMD_TAKE_OLDEST: begin
            res_in.action           = ACT_REWOUND;
            res_in.out_position     = rd_ff.position;
            res_in.out_orientation  = rd_ff.orientation;
            res_in.out_box_low      = rd_ff.box_low;
            res_in.out_box_high     = rd_ff.box_high;
            res_in.out_motion_flags = rd_ff.flags;
            if (undo_stamp_ff != req_ff.frame_time) begin
               undo_stamp_in            = req_ff.frame_time;
               undo_in.action           = ACT_RESTORED;
               undo_in.out_position     = req_ff.position;
               undo_in.out_orientation  = req_ff.orientation;
               undo_in.out_box_low      = req_ff.box_low;
               undo_in.out_box_high     = req_ff.box_high;
               undo_in.out_motion_flags = req_ff.motion_flags;
            end
         end
         CMD_LOAD_B: begin
            b_in                    = rd_ff;
            res_in.action           = ACT_REWOUND;
            res_in.out_motion_flags = rd_ff.flags;
            if (undo_stamp_ff != req_ff.frame_time) begin
               undo_stamp_in            = req_ff.frame_time;
               undo_in.action           = ACT_RESTORED;
               undo_in.out_position     = req_ff.position;
               undo_in.out_orientation  = req_ff.orientation;
               undo_in.out_box_low      = req_ff.box_low;
               undo_in.out_box_high     = req_ff.box_high;
               undo_in.out_motion_flags = req_ff.motion_flags;
            end
            rem_in     = {1'b0, q_ff - a_ff.sample};
            divisor_in = rd_ff.sample - a_ff.sample;
            div_ok_in  = (rd_ff.sample > a_ff.sample);
            quo_in     = 16'd0;
            div_cnt_in = 4'd0;
         end
         CMD_DIV_STEP: begin
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in = rem_shift - {1'b0, divisor_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 4'd1;
         end
         CMD_LERP_MUL: begin
            prod_in = diff * frac_s;
         end
         CMD_LERP_ADD: begin
            unique case (grp_ff)
               2'd0:    res_in.out_position[int'(sub_ff) * 20 +: 20] = lane_new;
               2'd1:    res_in.out_orientation[int'(sub_ff) * 16 +: 16] = lane_new[15:0];
               2'd2:    res_in.out_box_low[int'(sub_ff) * 20 +: 20] = lane_new;
               default: res_in.out_box_high[int'(sub_ff) * 20 +: 20] = lane_new;
            endcase
            if (sub_ff == 2'd2) begin
               sub_in = 2'd0;
               grp_in = grp_ff + 2'd1;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         CMD_RESTORE: begin
            if (undo_stamp_ff == req_ff.frame_time) begin
               res_in        = undo_ff;
               res_in.action = ACT_RESTORED;
               undo_stamp_in = 31'd0;
            end
         end
         CMD_EMIT: begin
            out_in       = res_ff;
            out_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         head_ff       <= '0;
         out_valid_ff  <= 1'b0;
         undo_stamp_ff <= '0;
         undo_ff       <= '0;
         div_cnt_ff    <= '0;
         grp_ff        <= '0;
         sub_ff        <= '0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
         head_ff       <= head_in;
         out_valid_ff  <= out_valid_in;
         undo_stamp_ff <= undo_stamp_in;
         undo_ff       <= undo_in;
         div_cnt_ff    <= div_cnt_in;
         grp_ff        <= grp_in;
         sub_ff        <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      q_ff       <= q_in;
      from_ff    <= from_in;
      to_ff      <= to_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      div_ok_ff  <= div_ok_in;
      prod_ff    <= prod_in;
   end

   assign status.hit       = (rd_ff.sample <= q_ff);
   assign status.first     = (from_ff == to_ff);
   assign status.wrap_next = (from_prev == head_ff);
   assign status.div_last  = (div_cnt_ff == 4'd15);
   assign status.lane_last = (grp_ff == 2'd3) && (sub_ff == 2'd2);
   assign status.out_busy  = out_valid_ff && !rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/timed_history_rewind_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// timed_history_rewind_interpolator_top
// Snapshot history of one object with time rewind, interpolation and undo.
// ----------------------------------------------------------------------------
// Channels: req_chan takes one transaction per operation (record, rewind,
// undo); rsp_chan returns exactly one transaction per request, in order.
// Both use valid/ready; a transaction moves when valid and ready are high.
// One request is processed at a time; req_chan.ready is high while idle.
// Steps from request to response, each ending in the result hand-off:
//   record: read the head entry, advance past it if older, write the new one;
//   undo: restore the undo slot; unknown opcode: the hand-off alone.
//   rewind: a read and a compare per entry visited by the backward search;
//   if two entries bracket the query, a load, a division for the 16-bit
//   fraction and twelve lane interpolations through one shared multiplier.
// The response sits in an output register; a stalled receiver holds the
// final step until the register frees, and a new request can be taken
// while the previous response waits.
// Reset (synchronous): clears the history valid bits (entries read as
// zero), the head pointer and the undo slot; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module timed_history_rewind_interpolator_top #(
   parameter int HISTORY_DEPTH = 32
) (
   input logic          clock,
   input logic          reset,
   thri_req_if.sink     req_chan,
   thri_rsp_if.source   rsp_chan
);
   import thri_pkg::*;

   req_type    req_data;
   rsp_type    rsp_data;
   cmd_type    cmd;
   status_type status;
   logic       rsp_valid;

   assign req_data.opcode              = req_chan.opcode;
   assign req_data.frame_time          = req_chan.frame_time;
   assign req_data.previous_frame_time = req_chan.previous_frame_time;
   assign req_data.elapsed_ms          = req_chan.elapsed_ms;
   assign req_data.is_bot              = req_chan.is_bot;
   assign req_data.query_time          = req_chan.query_time;
   assign req_data.position            = req_chan.position;
   assign req_data.orientation         = req_chan.orientation;
   assign req_data.box_low             = req_chan.box_low;
   assign req_data.box_high            = req_chan.box_high;
   assign req_data.motion_flags        = req_chan.motion_flags;

   thri_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .status     (status),
      .cmd        (cmd),
      .req_ready  (req_chan.ready)
   );

   thri_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.action           = rsp_data.action;
   assign rsp_chan.out_position     = rsp_data.out_position;
   assign rsp_chan.out_orientation  = rsp_data.out_orientation;
   assign rsp_chan.out_box_low      = rsp_data.out_box_low;
   assign rsp_chan.out_box_high     = rsp_data.out_box_high;
   assign rsp_chan.out_motion_flags = rsp_data.out_motion_flags;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a transaction is in progress");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !$rose(rsp_chan.valid))
      else $error("response raised in the cycle after acceptance");

   a_emit_only_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> !$past(req_chan.ready))
      else $error("response raised without a transaction in progress");
`endif

endmodule
